// ===== rtl/gnms_pkg.sv =====
// ----------------------------------------------------------------------------
// gnms_pkg
// Shared types, constants and helper functions of the gradient
// non-maximum suppression unit.
// ----------------------------------------------------------------------------
package gnms_pkg;

   // Line store depth and derived widths
   localparam int MAX_WIDTH  = 1024;
   localparam int MAX_HEIGHT = 1024;
   localparam int MIN_DIM    = 3;
   localparam int CFG_W      = 11;
   localparam int ADDR_W     = $clog2(MAX_WIDTH);
   localparam int WIDTH_W    = $clog2(MAX_WIDTH + 1);
   localparam int HEIGHT_W   = $clog2(MAX_HEIGHT + 1);
   // row counter runs through two drain rows past the last image row
   localparam int ROW_W      = $clog2(MAX_HEIGHT + 2);
   localparam int MAG_W      = 8;
   localparam int ANGLE_W    = 16;

   // Reset values of the frame size registers
   localparam int RESET_WIDTH  = 640;
   localparam int RESET_HEIGHT = 480;

   // Sector thresholds, 8192 units per radian
   localparam int ANG_22_5  = 3217;
   localparam int ANG_67_5  = 9651;
   localparam int ANG_112_5 = 16085;
   localparam int ANG_157_5 = 22519;
   localparam int ANG_PI    = 25735;

   typedef enum logic {
      OP_PIXEL = 1'b0,
      OP_FLUSH = 1'b1
   } op_type;

   typedef enum logic {
      CSR_FRAME_WIDTH  = 1'b0,
      CSR_FRAME_HEIGHT = 1'b1
   } csr_index_type;

   // Direction along which the neighbors are compared
   typedef enum logic [1:0] {
      SEC_HORZ      = 2'd0,
      SEC_DIAG_UP   = 2'd1,
      SEC_VERT      = 2'd2,
      SEC_DIAG_DOWN = 2'd3
   } sector_type;

   typedef struct packed {
      op_type                     op;
      logic [MAG_W-1:0]           grad_magnitude;
      logic signed [ANGLE_W-1:0]  grad_angle;
   } req_type;

   typedef struct packed {
      logic [MAG_W-1:0] thinned_value;
      logic             frame_end;
   } rsp_type;

   // One line store entry: upper and middle magnitude plus middle sector
   typedef struct packed {
      logic [MAG_W-1:0] upper;
      logic [MAG_W-1:0] middle;
      sector_type       sector;
   } line_word_type;

   // Item passed from the control stage to the window stage
   typedef struct packed {
      logic [ADDR_W-1:0] addr;
      logic [MAG_W-1:0]  value;
      sector_type        sector;
      logic              have;
      logic              border;
      logic              last;
   } item_type;

   function automatic sector_type quantize_angle(input logic signed [ANGLE_W-1:0] a);
      sector_type s;
      begin
         if (a >= 0) begin
            if (a < ANG_22_5)         s = SEC_HORZ;
            else if (a < ANG_67_5)    s = SEC_DIAG_UP;
            else if (a < ANG_112_5)   s = SEC_VERT;
            else if (a < ANG_157_5)   s = SEC_DIAG_DOWN;
            else if (a <= ANG_PI)     s = SEC_HORZ;
            else                      s = SEC_DIAG_DOWN;
         end else begin
            if (a < -ANG_PI)                  s = SEC_DIAG_DOWN;
            else if (a < -(ANG_157_5 - 1))    s = SEC_HORZ;
            else if (a < -(ANG_112_5 - 1))    s = SEC_DIAG_UP;
            else if (a < -(ANG_67_5 - 1))     s = SEC_VERT;
            else if (a < -(ANG_22_5 - 1))     s = SEC_DIAG_DOWN;
            else                              s = SEC_HORZ;
         end
         return s;
      end
   endfunction

   function automatic logic [WIDTH_W-1:0] clamp_width(input logic [CFG_W-1:0] v);
      logic [WIDTH_W-1:0] r;
      begin
         if (int'(v) < MIN_DIM)        r = WIDTH_W'(MIN_DIM);
         else if (int'(v) > MAX_WIDTH) r = WIDTH_W'(MAX_WIDTH);
         else                          r = WIDTH_W'(v);
         return r;
      end
   endfunction

   function automatic logic [HEIGHT_W-1:0] clamp_height(input logic [CFG_W-1:0] v);
      logic [HEIGHT_W-1:0] r;
      begin
         if (int'(v) < MIN_DIM)         r = HEIGHT_W'(MIN_DIM);
         else if (int'(v) > MAX_HEIGHT) r = HEIGHT_W'(MAX_HEIGHT);
         else                           r = HEIGHT_W'(v);
         return r;
      end
   endfunction

endpackage

// ===== rtl/gnms_line_ram.sv =====
// ----------------------------------------------------------------------------
// gnms_line_ram
// Line store: one write port, one read port, registered read data, with a
// bypass when a word is read at the address written in the same cycle.
// ----------------------------------------------------------------------------
module gnms_line_ram (
   input  logic                          clock,
   input  logic                          wr_en,
   input  logic [gnms_pkg::ADDR_W-1:0]   wr_addr,
   input  gnms_pkg::line_word_type       wr_data,
   input  logic                          rd_en,
   input  logic [gnms_pkg::ADDR_W-1:0]   rd_addr,
   output gnms_pkg::line_word_type       rd_data
);

   gnms_pkg::line_word_type line_mem [gnms_pkg::MAX_WIDTH];
   gnms_pkg::line_word_type rd_word_ff;
   gnms_pkg::line_word_type bypass_word_ff;
   logic                    bypass_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         line_mem[wr_addr] <= wr_data;
      end
   end

   // read port, old data plus bypass capture
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_word_ff     <= line_mem[rd_addr];
         bypass_ff      <= wr_en && (wr_addr == rd_addr);
         bypass_word_ff <= wr_data;
      end
   end

   assign rd_data = bypass_ff ? bypass_word_ff : rd_word_ff;

endmodule

// ===== rtl/gnms_ctrl.sv =====
// ----------------------------------------------------------------------------
// gnms_ctrl
// Front stage: frame size registers, raster counters, angle quantizer and
// line store read issue.
// ----------------------------------------------------------------------------
module gnms_ctrl (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_valid,
   input  gnms_pkg::csr_index_type       csr_index,
   input  logic [gnms_pkg::CFG_W-1:0]    csr_wdata,
   input  logic                          req_valid,
   input  gnms_pkg::req_type             req_data,
   input  logic                          advance,
   output logic                          rd_en,
   output logic [gnms_pkg::ADDR_W-1:0]   rd_addr,
   output logic                          item_valid,
   output gnms_pkg::item_type            item
);

   logic [gnms_pkg::CFG_W-1:0]    frame_width_ff, frame_width_in;
   logic [gnms_pkg::CFG_W-1:0]    frame_height_ff, frame_height_in;
   logic [gnms_pkg::WIDTH_W-1:0]  act_w_ff, act_w_in;
   logic [gnms_pkg::HEIGHT_W-1:0] act_h_ff, act_h_in;
   logic [gnms_pkg::ADDR_W-1:0]   col_ff, col_in;
   logic [gnms_pkg::ROW_W-1:0]    row_ff, row_in;
   logic                          item_valid_ff, item_valid_in;
   gnms_pkg::item_type            item_ff, item_in;

   logic                          in_frame;
   logic                          live;
   logic                          first;
   logic                          col_nz;
   logic [gnms_pkg::WIDTH_W-1:0]  eff_w;
   logic [gnms_pkg::HEIGHT_W-1:0] eff_h;
   logic [gnms_pkg::WIDTH_W-1:0]  col_plus;
   logic                          wrap;
   logic [gnms_pkg::ROW_W-1:0]    centre_row;
   logic [gnms_pkg::ROW_W-1:0]    last_row;
   logic                          have;
   logic                          border;
   logic                          last;

   // config writes
   always_comb begin
      frame_width_in  = frame_width_ff;
      frame_height_in = frame_height_ff;
      if (csr_valid) begin
         unique case (csr_index)
            gnms_pkg::CSR_FRAME_WIDTH:  frame_width_in  = csr_wdata;
            gnms_pkg::CSR_FRAME_HEIGHT: frame_height_in = csr_wdata;
         endcase
      end
   end

   // item classification: a flush inside the frame is dropped
   assign in_frame = row_ff < gnms_pkg::ROW_W'(act_h_ff);
   assign live     = req_valid && advance &&
                     !(in_frame && (req_data.op == gnms_pkg::OP_FLUSH));
   assign col_nz   = (col_ff != '0);
   assign first    = in_frame && (row_ff == '0) && !col_nz;

   // frame size is latched on the first pixel and used by that pixel too
   assign eff_w = first ? gnms_pkg::clamp_width(frame_width_ff)  : act_w_ff;
   assign eff_h = first ? gnms_pkg::clamp_height(frame_height_ff) : act_h_ff;

   // position of the centre pixel behind this item
   assign centre_row = col_nz ? (row_ff - gnms_pkg::ROW_W'(1))
                              : (row_ff - gnms_pkg::ROW_W'(2));
   assign last_row   = gnms_pkg::ROW_W'(eff_h) - gnms_pkg::ROW_W'(1);
   assign have       = (row_ff >= gnms_pkg::ROW_W'(2)) ||
                       ((row_ff == gnms_pkg::ROW_W'(1)) && col_nz);
   // centre column is col-1, or the last column when col is zero
   assign border     = (centre_row == '0) || (centre_row == last_row) ||
                       (col_ff == gnms_pkg::ADDR_W'(1)) || !col_nz;
   assign last       = (centre_row == last_row) && !col_nz;

   assign col_plus = gnms_pkg::WIDTH_W'(col_ff) + gnms_pkg::WIDTH_W'(1);
   assign wrap     = (col_plus >= eff_w);

   // counters and latched frame size
   always_comb begin
      act_w_in = act_w_ff;
      act_h_in = act_h_ff;
      col_in   = col_ff;
      row_in   = row_ff;
      if (live) begin
         act_w_in = eff_w;
         act_h_in = eff_h;
         if (have && last) begin
            col_in = '0;
            row_in = '0;
         end else if (wrap) begin
            col_in = '0;
            row_in = row_ff + gnms_pkg::ROW_W'(1);
         end else begin
            col_in = col_plus[gnms_pkg::ADDR_W-1:0];
         end
      end
   end

   // stage register toward the window
   always_comb begin
      item_valid_in = advance ? live : item_valid_ff;
      item_in       = item_ff;
      if (live) begin
         item_in.addr   = col_ff;
         item_in.value  = in_frame ? req_data.grad_magnitude : '0;
         item_in.sector = in_frame ? gnms_pkg::quantize_angle(req_data.grad_angle)
                                   : gnms_pkg::SEC_HORZ;
         item_in.have   = have;
         item_in.border = border;
         item_in.last   = last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= gnms_pkg::CFG_W'(gnms_pkg::RESET_WIDTH);
         frame_height_ff <= gnms_pkg::CFG_W'(gnms_pkg::RESET_HEIGHT);
         act_w_ff        <= gnms_pkg::clamp_width(gnms_pkg::CFG_W'(gnms_pkg::RESET_WIDTH));
         act_h_ff        <= gnms_pkg::clamp_height(gnms_pkg::CFG_W'(gnms_pkg::RESET_HEIGHT));
         col_ff          <= '0;
         row_ff          <= '0;
         item_valid_ff   <= 1'b0;
      end else begin
         frame_width_ff  <= frame_width_in;
         frame_height_ff <= frame_height_in;
         act_w_ff        <= act_w_in;
         act_h_ff        <= act_h_in;
         col_ff          <= col_in;
         row_ff          <= row_in;
         item_valid_ff   <= item_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
   end

   assign rd_en      = live;
   assign rd_addr    = col_ff;
   assign item_valid = item_valid_ff;
   assign item       = item_ff;

endmodule

// ===== rtl/gnms_window.sv =====
// ----------------------------------------------------------------------------
// gnms_window
// Window stage: takes the line store column, writes the shifted column
// back, shifts the 3x3 window, compares the centre and registers the word.
// ----------------------------------------------------------------------------
module gnms_window (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          advance,
   input  logic                          item_valid,
   input  gnms_pkg::item_type            item,
   input  gnms_pkg::line_word_type       rd_word,
   output logic                          wr_en,
   output logic [gnms_pkg::ADDR_W-1:0]   wr_addr,
   output gnms_pkg::line_word_type       wr_data,
   output logic                          rsp_valid,
   output gnms_pkg::rsp_type             rsp_data
);

   logic [gnms_pkg::MAG_W-1:0] win_ff [3][3];
   logic [gnms_pkg::MAG_W-1:0] win_in [3][3];
   gnms_pkg::sector_type       sec_dly_ff, sec_dly_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   gnms_pkg::rsp_type          rsp_data_ff, rsp_data_in;

   logic                       step;
   logic [gnms_pkg::MAG_W-1:0] centre;
   logic [gnms_pkg::MAG_W-1:0] na;
   logic [gnms_pkg::MAG_W-1:0] nb;
   logic                       keep;

   assign step = advance && item_valid;

   // read-modify-write of the line entry: middle moves up, new pixel enters
   assign wr_en   = step;
   assign wr_addr = item.addr;
   assign wr_data = '{upper: rd_word.middle, middle: item.value, sector: item.sector};

   // window shift, new column on the right
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         win_in[k][0] = step ? win_ff[k][1] : win_ff[k][0];
         win_in[k][1] = step ? win_ff[k][2] : win_ff[k][1];
         win_in[k][2] = win_ff[k][2];
      end
      if (step) begin
         win_in[0][2] = rd_word.upper;
         win_in[1][2] = rd_word.middle;
         win_in[2][2] = item.value;
      end
   end

   // sector of the centre trails the line store by one column
   assign sec_dly_in = step ? rd_word.sector : sec_dly_ff;

   // neighbors in the shifted window, taken from the current one
   assign centre = win_ff[1][2];
   always_comb begin
      unique case (sec_dly_ff)
         gnms_pkg::SEC_HORZ: begin
            na = win_ff[1][1];
            nb = rd_word.middle;
         end
         gnms_pkg::SEC_DIAG_UP: begin
            na = rd_word.upper;
            nb = win_ff[2][1];
         end
         gnms_pkg::SEC_VERT: begin
            na = win_ff[0][2];
            nb = win_ff[2][2];
         end
         gnms_pkg::SEC_DIAG_DOWN: begin
            na = win_ff[0][1];
            nb = item.value;
         end
      endcase
   end

   assign keep = !(centre < na) && !(centre < nb) && !item.border;

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (advance) begin
         rsp_valid_in              = item_valid && item.have;
         rsp_data_in.thinned_value = keep ? centre : '0;
         rsp_data_in.frame_end     = item.last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < 3; k++) begin
            for (int j = 0; j < 3; j++) begin
               win_ff[k][j] <= '0;
            end
         end
         sec_dly_ff   <= gnms_pkg::SEC_HORZ;
         rsp_valid_ff <= 1'b0;
      end else begin
         win_ff       <= win_in;
         sec_dly_ff   <= sec_dly_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== rtl/gradient_non_maximum_suppression_unit.sv =====
// ----------------------------------------------------------------------------
// gradient_non_maximum_suppression_unit
// Streaming 3x3 Canny non-maximum suppression over a raster of gradient
// magnitudes and angles, with line stores in one synchronous memory.
//
//   channel  direction  handshake              word
//   req      in         req_valid/req_ready    gnms_pkg::req_type
//   rsp      out        rsp_valid/rsp_ready    gnms_pkg::rsp_type
//   csr      in         csr_valid/csr_ready    csr_index, csr_wdata
//
// One word per clock while rsp is not stalled; the front-stage line store
// read and window-stage write-back overlap, so one read and one write port
// set that rate. Words pass the item register, then the output register.
// No clearing pass after reset: unwritten entries only reach border results.
// A stalled rsp holds the whole pipe; req_ready drops only then.
// ----------------------------------------------------------------------------
module gradient_non_maximum_suppression_unit (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  gnms_pkg::req_type             req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output gnms_pkg::rsp_type             rsp_data,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  gnms_pkg::csr_index_type       csr_index,
   input  logic [gnms_pkg::CFG_W-1:0]    csr_wdata
);

   logic                          advance;
   logic                          rd_en;
   logic [gnms_pkg::ADDR_W-1:0]   rd_addr;
   gnms_pkg::line_word_type       rd_word;
   logic                          wr_en;
   logic [gnms_pkg::ADDR_W-1:0]   wr_addr;
   gnms_pkg::line_word_type       wr_data;
   logic                          item_valid;
   gnms_pkg::item_type            item;

   // pipe moves whenever the output register is free or being drained
   assign advance   = !rsp_valid || rsp_ready;
   assign req_ready = advance;
   assign csr_ready = 1'b1;

   gnms_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_valid  (req_valid),
      .req_data   (req_data),
      .advance    (advance),
      .rd_en      (rd_en),
      .rd_addr    (rd_addr),
      .item_valid (item_valid),
      .item       (item)
   );

   gnms_line_ram u_line_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_word)
   );

   gnms_window u_window (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .item_valid (item_valid),
      .item       (item),
      .rd_word    (rd_word),
      .wr_en      (wr_en),
      .wr_addr    (wr_addr),
      .wr_data    (wr_data),
      .rsp_valid  (rsp_valid),
      .rsp_data   (rsp_data)
   );

   // same-entry read and write only across a frame boundary
   assert property (@(posedge clock) disable iff (reset)
      (rd_en && wr_en && (rd_addr == wr_addr)) |-> item.last)
      else $error("line store read/write collision outside frame end");

   // a stalled window stage keeps its word
   assert property (@(posedge clock) disable iff (reset)
      (item_valid && !advance) |=> (item_valid && $stable(item)))
      else $error("window stage word lost during stall");

   // a new result only follows a word that owns one
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(item_valid && item.have && advance))
      else $error("result without a producing word");

   // the frame end result sits on the border and is always zero
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.frame_end) |-> (rsp_data.thinned_value == '0))
      else $error("frame end result not zero");

endmodule
